>>> src/sapd_pkg.sv
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types and constants of the steering angle PD controller.
// ----------------------------------------------------------------------------
package sapd_pkg;

  localparam int unsigned ADDR_W    = 5;

  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_ANGLE_LO        = 3'd1;
  localparam logic [2:0] REG_ANGLE_HI        = 3'd2;
  localparam logic [2:0] REG_VELOCITY_GAP    = 3'd3;
  localparam logic [2:0] REG_MOVE_THRESHOLD  = 3'd4;
  localparam logic [2:0] REG_KP_GAIN         = 3'd5;
  localparam logic [2:0] REG_KD_GAIN         = 3'd6;
  localparam logic [2:0] REG_SETPOINT        = 3'd7;

  // pi/180 in Q24
  localparam logic signed [19:0] DEG2RAD_Q24 = 20'sd292818;
  localparam logic signed [23:0] VEL_MAX     = 24'sh7FFFFF;
  localparam logic signed [23:0] VEL_MIN     = 24'sh800000;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_MAP    = 4'd1,  // product adc * span
    OP_ROUND  = 4'd2,  // start rounding divide by full scale
    OP_ANGLE  = 4'd3,  // take angle
    OP_QSTART = 4'd4,  // evaluate gap and movement, latch difference for the quotient divide
    OP_VMOVE  = 4'd5,  // velocity mean with quotient
    OP_VDECAY = 4'd6,  // velocity halving
    OP_PD0    = 4'd7,  // angle error and rate terms
    OP_PD1    = 4'd8,  // kp term product
    OP_PD2    = 4'd9,  // kd term product
    OP_PD3    = 4'd10, // sum, clamp and output
    OP_ACCEPT = 4'd11  // interval check and latch input
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } sapd_cmd_t;

  typedef struct packed {
    logic drop;      // sample too early
    logic gap_ok;    // velocity gap passed
    logic moved;     // angle moved enough
    logic div_busy;
    logic rnd_busy;  // division by full scale running
  } sapd_stat_t;

  typedef struct packed {
    logic [15:0]        sample_interval_ms;
    logic signed [16:0] angle_lo;
    logic signed [16:0] angle_hi;
    logic [15:0]        velocity_gap_ms;
    logic [15:0]        move_threshold;
    logic [15:0]        kp_gain;
    logic [15:0]        kd_gain;
    logic signed [14:0] setpoint_rad;
  } sapd_cfg_t;

endpackage

>>> src/sapd_div.sv
// ----------------------------------------------------------------------------
// sapd_div
// Restoring divider, unsigned magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sapd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [39:0] quotient
);

  logic [5:0]  count;
  logic [32:0] rem;
  logic [39:0] quo;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem[31:0], quo[39]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'd40;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[38:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

>>> src/sapd_datapath.sv
// ----------------------------------------------------------------------------
// sapd_datapath
// Angle mapping, velocity estimate and PD law, stepped by the controller.
// ----------------------------------------------------------------------------
module sapd_datapath #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sapd_pkg::sapd_cmd_t   cmd,
  output sapd_pkg::sapd_stat_t  stat,
  input  sapd_pkg::sapd_cfg_t   cfg,
  input  logic [31:0]           in_now_ms,
  input  logic [ADC_BITS-1:0]   in_adc,
  output logic signed [16:0]    angle,
  output logic signed [23:0]    ang_rate,
  output logic signed [15:0]    control_out
);

  localparam logic [ADC_BITS-1:0] FS      = {ADC_BITS{1'b1}};
  localparam logic [31:0]         FS_HALF = 32'(FS >> 1);
  localparam logic [35:0]         FS_W    = 36'(FS);

  localparam logic signed [29:0] VEL_MAX_W = 30'sd8388607;
  localparam logic signed [29:0] VEL_MIN_W = -30'sd8388608;

  // persistent state
  logic [31:0]        last_sample_ms;
  logic signed [16:0] latched_angle;
  logic signed [16:0] control_angle;
  logic [31:0]        latched_angle_ms;
  logic signed [23:0] velocity;

  // working registers
  logic [31:0]        now_r;
  logic [ADC_BITS-1:0] adc_r;
  logic signed [35:0] prod;
  logic               prod_neg;
  logic signed [17:0] diff;
  logic               diff_neg;
  logic [31:0]        dt;
  logic signed [47:0] term_a;
  logic signed [47:0] term_b;
  logic signed [63:0] kterm_p;
  logic signed [63:0] kterm_d;
  logic               drop_r;
  logic               gap_ok_r;
  logic               moved_r;

  // division by full scale: fold the high digits onto the low ones
  logic [35:0]        rnd_r;
  logic [35:0]        rnd_q;
  logic [35:0]        rnd_hi;
  logic               rnd_busy;

  // divider
  logic        div_start;
  logic [39:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_busy;
  logic [39:0] div_q;

  sapd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  logic [35:0]        prod_mag;
  logic [17:0]        diff_mag;
  logic [27:0]        diff_scaled;
  logic signed [17:0] span;
  logic signed [17:0] ang_wide;
  logic signed [17:0] new_diff;
  logic [17:0]        new_adiff;
  logic [31:0]        dt_now;
  logic signed [29:0] vsum;
  logic signed [29:0] vmean;
  logic signed [23:0] vhalf;
  logic signed [40:0] qv;
  logic signed [66:0] pd_sum;
  logic signed [66:0] pd_clamp;
  logic [66:0]        pd_biased;
  logic [40:0]        q14;

  assign span      = 18'(cfg.angle_hi) - 18'(cfg.angle_lo);
  assign prod_mag  = prod[35] ? 36'(-prod) : 36'(prod);
  assign diff_mag  = diff_neg ? 18'(-diff) : 18'(diff);
  assign diff_scaled = 28'(diff_mag) * 28'd1000;

  assign div_start    = cmd.div_start;
  assign div_dividend = 40'(diff_scaled);
  assign div_divisor  = (dt == 32'd0) ? 32'd1 : dt;

  assign rnd_hi = rnd_r >> ADC_BITS;

  assign ang_wide  = prod_neg ? (18'(cfg.angle_lo) - 18'(rnd_q[17:0]))
                              : (18'(cfg.angle_lo) + 18'(rnd_q[17:0]));
  assign new_diff  = 18'(angle) - 18'(latched_angle);
  assign new_adiff = new_diff[17] ? 18'(-new_diff) : 18'(new_diff);
  assign dt_now    = now_r - latched_angle_ms;

  assign qv    = diff_neg ? -41'(div_q) : 41'(div_q);
  assign vsum  = 30'(velocity) + 30'(qv[29:0]);
  assign vmean = (vsum + ((vsum < 0) ? 30'sd1 : 30'sd0)) >>> 1;
  assign vhalf = (velocity + ((velocity < 0) ? 24'sd1 : 24'sd0)) >>> 1;

  assign pd_sum   = 67'(kterm_p) - 67'(kterm_d);
  assign pd_clamp = (pd_sum > 67'sd1099511627776) ? 67'sd1099511627776 :
                    (pd_sum < -67'sd1099511627776) ? -67'sd1099511627776 : pd_sum;
  assign pd_biased = 67'(pd_clamp + 67'sd1099511627776 + 67'sd33554432);
  assign q14       = pd_biased[66:26];

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_busy <= 1'b0;
    end else if (cmd.op == sapd_pkg::OP_ROUND) begin
      rnd_busy <= 1'b1;
    end else if (rnd_busy && rnd_hi == '0) begin
      rnd_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sapd_pkg::OP_ROUND) begin
      rnd_r <= prod_mag + 36'(FS_HALF);
      rnd_q <= '0;
    end else if (rnd_busy) begin
      if (rnd_hi != '0) begin
        rnd_q <= rnd_q + rnd_hi;
        rnd_r <= rnd_hi + (rnd_r & FS_W);
      end else if (rnd_r == FS_W) begin
        rnd_q <= rnd_q + 36'd1;
        rnd_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_ms   <= '0;
      latched_angle    <= '0;
      control_angle    <= '0;
      latched_angle_ms <= '0;
      velocity         <= '0;
      drop_r           <= 1'b0;
      gap_ok_r         <= 1'b0;
      moved_r          <= 1'b0;
    end else begin
      case (cmd.op)
        sapd_pkg::OP_ACCEPT: begin
          now_r <= in_now_ms;
          adc_r <= in_adc;
          drop_r <= (in_now_ms - last_sample_ms) < 32'(cfg.sample_interval_ms);
          if (!((in_now_ms - last_sample_ms) < 32'(cfg.sample_interval_ms))) begin
            last_sample_ms <= in_now_ms;
          end
        end
        sapd_pkg::OP_MAP: begin
          prod     <= 36'($signed({1'b0, adc_r})) * 36'(span);
          prod_neg <= 1'b0;
        end
        sapd_pkg::OP_ROUND: begin
          prod_neg <= prod[35];
        end
        sapd_pkg::OP_ANGLE: begin
          angle <= ang_wide[16:0];
        end
        sapd_pkg::OP_QSTART: begin
          // evaluate the gap and movement on the fresh angle
          dt          <= dt_now;
          gap_ok_r    <= dt_now >= 32'(cfg.velocity_gap_ms);
          moved_r     <= new_adiff >= 18'(cfg.move_threshold);
          diff        <= new_diff;
          diff_neg    <= new_diff[17];
          if (dt_now >= 32'(cfg.velocity_gap_ms)) begin
            control_angle <= angle;
          end
        end
        sapd_pkg::OP_VMOVE: begin
          if (vmean > VEL_MAX_W) velocity <= sapd_pkg::VEL_MAX;
          else if (vmean < VEL_MIN_W) velocity <= sapd_pkg::VEL_MIN;
          else velocity <= vmean[23:0];
          latched_angle    <= angle;
          latched_angle_ms <= now_r;
        end
        sapd_pkg::OP_VDECAY: begin
          if (vhalf < 24'sd256 && vhalf > -24'sd256) velocity <= '0;
          else velocity <= vhalf;
        end
        sapd_pkg::OP_PD0: begin
          term_a <= 48'(cfg.setpoint_rad) * 48'sd1048576
                    - 48'(control_angle) * 48'(sapd_pkg::DEG2RAD_Q24);
          term_b <= 48'(velocity) * 48'(sapd_pkg::DEG2RAD_Q24);
        end
        sapd_pkg::OP_PD1: begin
          kterm_p <= 64'(term_a) * 64'($signed({1'b0, cfg.kp_gain}));
        end
        sapd_pkg::OP_PD2: begin
          kterm_d <= 64'(term_b) * 64'($signed({1'b0, cfg.kd_gain}));
        end
        sapd_pkg::OP_PD3: begin
          ang_rate    <= velocity;
          control_out <= 16'(q14 - 41'd16384);
        end
        default: begin
        end
      endcase
    end
  end

  assign stat = '{drop: drop_r, gap_ok: gap_ok_r, moved: moved_r,
                  div_busy: div_busy, rnd_busy: rnd_busy};

endmodule

>>> src/sapd_ctrl.sv
// ----------------------------------------------------------------------------
// sapd_ctrl
// Sequencer: steps the datapath through one sample and runs the handshake.
// ----------------------------------------------------------------------------
module sapd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sapd_pkg::sapd_cmd_t  cmd,
  input  sapd_pkg::sapd_stat_t stat
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CHECK  = 14'b00000000000010,
    S_MAP    = 14'b00000000000100,
    S_RDIV   = 14'b00000000001000,
    S_RWAIT  = 14'b00000000010000,
    S_ANGLE  = 14'b00000000100000,
    S_GAP    = 14'b00000001000000,
    S_QWAIT  = 14'b00000010000000,
    S_VUPD   = 14'b00000100000000,
    S_PD0    = 14'b00001000000000,
    S_PD1    = 14'b00010000000000,
    S_PD2    = 14'b00100000000000,
    S_PD3    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    cmd.op        = sapd_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op     = sapd_pkg::OP_ACCEPT;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = stat.drop ? S_IDLE : S_MAP;
      S_MAP: begin
        cmd.op     = sapd_pkg::OP_MAP;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.op     = sapd_pkg::OP_ROUND;
        state_next = S_RWAIT;
      end
      S_RWAIT: if (!stat.rnd_busy) state_next = S_ANGLE;
      S_ANGLE: begin
        cmd.op     = sapd_pkg::OP_ANGLE;
        state_next = S_GAP;
      end
      S_GAP: begin
        cmd.op     = sapd_pkg::OP_QSTART;
        state_next = S_QWAIT;
      end
      S_QWAIT: begin
        // divide the scaled difference only when it is needed
        if (stat.gap_ok && stat.moved) begin
          cmd.div_start = 1'b1;
          state_next    = S_VUPD;
        end else if (stat.gap_ok) begin
          cmd.op     = sapd_pkg::OP_VDECAY;
          state_next = S_PD0;
        end else begin
          state_next = S_PD0;
        end
      end
      S_VUPD: begin
        if (!stat.div_busy) begin
          cmd.op     = sapd_pkg::OP_VMOVE;
          state_next = S_PD0;
        end
      end
      S_PD0: begin
        cmd.op     = sapd_pkg::OP_PD0;
        state_next = S_PD1;
      end
      S_PD1: begin
        cmd.op     = sapd_pkg::OP_PD1;
        state_next = S_PD2;
      end
      S_PD2: begin
        cmd.op     = sapd_pkg::OP_PD2;
        state_next = S_PD3;
      end
      S_PD3: begin
        cmd.op     = sapd_pkg::OP_PD3;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/steering_angle_pd_controller.sv
// A sample without movement skips the velocity divide, so its result comes sooner than one with
// movement; a dropped sample frees the input right after the interval check.
// Throughput: one sample at a time, the next input transaction in the cycle after the result
// is taken; the bit-serial velocity divide sets the worst case, and the folding
// division by full scale repeats until no high digits remain. Each multiply is registered.
// Reset: synchronous, active high; configuration and persistent registers return to reset values, state clears.
// ----------------------------------------------------------------------------
// steering_angle_pd_controller
// Maps ADC samples to a steering angle, estimates velocity, runs a PD law.
// ----------------------------------------------------------------------------
module steering_angle_pd_controller #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] now_ms, [31+ADC_BITS:32] adc_sample, zero fill to whole bytes
  input  logic [((32+ADC_BITS+7)/8)*8-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [16:0] angle, [40:17] ang_rate, [56:41] control_out, [63:57] zero
  output logic [63:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sapd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sapd_pkg::sapd_cfg_t  cfg;
  sapd_pkg::sapd_cmd_t  cmd;
  sapd_pkg::sapd_stat_t stat;
  logic                 in_fire;
  logic [2:0]           reg_idx;
  logic signed [16:0]   angle;
  logic signed [23:0]   ang_rate;
  logic signed [15:0]   control_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms <= 16'd10;
      cfg.angle_lo           <= -17'sd7680;
      cfg.angle_hi           <= 17'sd7680;
      cfg.velocity_gap_ms    <= 16'd20;
      cfg.move_threshold     <= 16'd77;
      cfg.kp_gain            <= 16'd1024;
      cfg.kd_gain            <= 16'd256;
      cfg.setpoint_rad       <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        sapd_pkg::REG_SAMPLE_INTERVAL: cfg.sample_interval_ms <= pwdata[15:0];
        sapd_pkg::REG_ANGLE_LO:        cfg.angle_lo           <= pwdata[16:0];
        sapd_pkg::REG_ANGLE_HI:        cfg.angle_hi           <= pwdata[16:0];
        sapd_pkg::REG_VELOCITY_GAP:    cfg.velocity_gap_ms    <= pwdata[15:0];
        sapd_pkg::REG_MOVE_THRESHOLD:  cfg.move_threshold     <= pwdata[15:0];
        sapd_pkg::REG_KP_GAIN:         cfg.kp_gain            <= pwdata[15:0];
        sapd_pkg::REG_KD_GAIN:         cfg.kd_gain            <= pwdata[15:0];
        sapd_pkg::REG_SETPOINT:        cfg.setpoint_rad       <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        sapd_pkg::REG_SAMPLE_INTERVAL: prdata = 32'(cfg.sample_interval_ms);
        sapd_pkg::REG_ANGLE_LO:        prdata = 32'(cfg.angle_lo);
        sapd_pkg::REG_ANGLE_HI:        prdata = 32'(cfg.angle_hi);
        sapd_pkg::REG_VELOCITY_GAP:    prdata = 32'(cfg.velocity_gap_ms);
        sapd_pkg::REG_MOVE_THRESHOLD:  prdata = 32'(cfg.move_threshold);
        sapd_pkg::REG_KP_GAIN:         prdata = 32'(cfg.kp_gain);
        sapd_pkg::REG_KD_GAIN:         prdata = 32'(cfg.kd_gain);
        sapd_pkg::REG_SETPOINT:        prdata = 32'(cfg.setpoint_rad);
        default:                       prdata = '0;
      endcase
    end
  end

  sapd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sapd_datapath #(.ADC_BITS(ADC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .in_now_ms   (s_tdata[31:0]),
    .in_adc      (s_tdata[32 +: ADC_BITS]),
    .angle       (angle),
    .ang_rate    (ang_rate),
    .control_out (control_out)
  );

  assign m_tdata = {7'd0, control_out, ang_rate, angle};

  // the result stays put while it waits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // no new sample is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready with result pending");

  // drive value never leaves plus or minus one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (control_out <= 16'sd16384 && control_out >= -16'sd16384))
    else $error("control_out out of range");

endmodule
